// ===== sv/xed_pkg.sv =====
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types and constants of the XML entity decoder: character codes,
// output source selection, segment positions and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package xed_pkg;

  // Default longest entity name that is held.
  localparam int NAME_LIMIT_DEF = 11;

  // Characters with a structural meaning.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Largest valid code point.
  localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

  // Positions of the output segments, in the order they are emitted.
  localparam int SEG_REL1 = 0;
  localparam int SEG_DEC  = 1;
  localparam int SEG_SEMI = 2;
  localparam int SEG_LIT  = 3;
  localparam int SEG_REL2 = 4;
  localparam int SEG_N    = 5;

  // Source of the byte loaded into the output register.
  typedef enum logic [2:0] {
    SRC_IN,
    SRC_REL,
    SRC_DEC,
    SRC_SEMI,
    SRC_LIT
  } src_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     append;
    logic     open;
    logic     clr_name;
    logic     clr_ent;
    logic     load;
    logic     run_end;
    src_sel_t sel;
  } xed_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ent;
    logic full;
    logic in_amp;
    logic in_semi;
    logic known;
    logic rel_end;
    logic dec_end;
    logic out_free;
  } xed_stat_t;

  // Value of a digit in base ten or sixteen; the top bit flags a valid digit.
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== sv/xed_datapath.sv =====
// ----------------------------------------------------------------------------
// xed_datapath
// Name buffer, running code point, entity recognition, UTF-8 encoder and the
// output register of the XML entity decoder.
// ----------------------------------------------------------------------------
module xed_datapath #(
  parameter int NAME_LIMIT = xed_pkg::NAME_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  xed_pkg::xed_cmd_t               cmd,
  input  logic [$clog2(NAME_LIMIT+1)-1:0] idx,
  output xed_pkg::xed_stat_t              st,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_run_end,
  output logic                            out_text_end
);
  import xed_pkg::*;

  localparam int CW = $clog2(NAME_LIMIT + 1);
  localparam int IW = $clog2(NAME_LIMIT);

  logic          ent_r, ent_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    name_r [NAME_LIMIT];
  logic          hash_r, hex_r, dig_on_r;
  logic [31:0]   cp_r;
  logic [7:0]    lit_r;
  logic          last_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          run_end_r, text_end_r;

  logic [4:0]    dig;
  logic [31:0]   cp_step;
  logic          named_hit, numeric;
  logic [7:0]    named_byte;
  logic [20:0]   cpf;
  logic [1:0]    dec_last;
  logic [7:0]    dec_b [4];
  logic [IW-1:0] rd_idx;
  logic [7:0]    out_sel_byte;

  // Next digit of the numeric reference, accumulated as name bytes arrive.
  assign dig     = digit_val(in_byte, hex_r);
  assign cp_step = hex_r ? ({cp_r[27:0], 4'b0000} + 32'(dig[3:0]))
                         : ((cp_r << 3) + (cp_r << 1) + 32'(dig[3:0]));

  // Entity state and name count.
  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (cmd.append) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.open) begin
      ent_nxt = 1'b1;
      cnt_nxt = '0;
    end
    if (cmd.clr_name) begin
      cnt_nxt = '0;
    end
    if (cmd.clr_ent) begin
      ent_nxt = 1'b0;
    end
  end

  // Output register is free when empty or being taken this cycle.
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ent_r       <= ent_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Name buffer and numeric parse state; only read below the name count.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lit_r  <= in_byte;
      last_r <= in_last;
    end
    if (cmd.append) begin
      name_r[IW'(cnt_r)] <= in_byte;
      if (cnt_r == '0) begin
        hash_r   <= (in_byte == CH_HASH);
        hex_r    <= 1'b0;
        dig_on_r <= 1'b1;
        cp_r     <= '0;
      end else if (cnt_r == CW'(1) && (in_byte == CH_LX || in_byte == CH_UX)) begin
        hex_r <= 1'b1;
      end else if (dig_on_r) begin
        if (dig[4]) begin
          cp_r <= cp_step;
        end else begin
          dig_on_r <= 1'b0;
        end
      end
    end
  end

  // Recognition of the named entities.
  always_comb begin
    named_hit  = 1'b1;
    named_byte = CH_AMP;
    if (cnt_r == CW'(3) && {name_r[0], name_r[1], name_r[2]} == "amp") begin
      named_byte = CH_AMP;
    end else if (cnt_r == CW'(2) && {name_r[0], name_r[1]} == "lt") begin
      named_byte = 8'h3C;
    end else if (cnt_r == CW'(2) && {name_r[0], name_r[1]} == "gt") begin
      named_byte = 8'h3E;
    end else if (cnt_r == CW'(4) &&
                 {name_r[0], name_r[1], name_r[2], name_r[3]} == "quot") begin
      named_byte = 8'h22;
    end else if (cnt_r == CW'(4) &&
                 {name_r[0], name_r[1], name_r[2], name_r[3]} == "apos") begin
      named_byte = 8'h27;
    end else if (cnt_r == CW'(4) &&
                 {name_r[0], name_r[1], name_r[2], name_r[3]} == "nbsp") begin
      named_byte = 8'h20;
    end else begin
      named_hit = 1'b0;
    end
  end

  assign numeric = hash_r && (cnt_r > CW'(1));

  // UTF-8 encoding of the code point; invalid values become a question mark.
  always_comb begin
    if (cp_r == '0 || cp_r > CP_MAX) begin
      cpf = 21'(CH_QMARK);
    end else begin
      cpf = cp_r[20:0];
    end
    dec_b[0] = 8'h00;
    dec_b[1] = 8'h00;
    dec_b[2] = 8'h00;
    dec_b[3] = 8'h00;
    if (named_hit) begin
      dec_last = 2'd0;
      dec_b[0] = named_byte;
    end else if (cpf < 21'h80) begin
      dec_last = 2'd0;
      dec_b[0] = cpf[7:0];
    end else if (cpf < 21'h800) begin
      dec_last = 2'd1;
      dec_b[0] = {3'b110, cpf[10:6]};
      dec_b[1] = {2'b10, cpf[5:0]};
    end else if (cpf < 21'h10000) begin
      dec_last = 2'd2;
      dec_b[0] = {4'b1110, cpf[15:12]};
      dec_b[1] = {2'b10, cpf[11:6]};
      dec_b[2] = {2'b10, cpf[5:0]};
    end else begin
      dec_last = 2'd3;
      dec_b[0] = {5'b11110, cpf[20:18]};
      dec_b[1] = {2'b10, cpf[17:12]};
      dec_b[2] = {2'b10, cpf[11:6]};
      dec_b[3] = {2'b10, cpf[5:0]};
    end
  end

  // Released literals: the ampersand first, then the held name bytes.
  assign rd_idx = (idx == '0) ? '0 : IW'(idx - CW'(1));

  always_comb begin
    case (cmd.sel)
      SRC_IN:   out_sel_byte = in_byte;
      SRC_REL:  out_sel_byte = (idx == '0) ? CH_AMP : name_r[rd_idx];
      SRC_DEC:  out_sel_byte = dec_b[idx[1:0]];
      SRC_SEMI: out_sel_byte = CH_SEMI;
      SRC_LIT:  out_sel_byte = lit_r;
      default:  out_sel_byte = lit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_byte_r <= out_sel_byte;
      run_end_r  <= cmd.run_end;
      text_end_r <= cmd.run_end && ((cmd.sel == SRC_IN) ? in_last : last_r);
    end
  end

  // Status towards the controller.
  always_comb begin
    st.ent      = ent_r;
    st.full     = (cnt_r == CW'(NAME_LIMIT));
    st.in_amp   = (in_byte == CH_AMP);
    st.in_semi  = (in_byte == CH_SEMI);
    st.known    = named_hit || numeric;
    st.rel_end  = (idx == cnt_r);
    st.dec_end  = (idx[1:0] == dec_last);
    st.out_free = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_end  = run_end_r;
  assign out_text_end = text_end_r;

`ifndef SYNTHESIS
  // The name count never passes the buffer depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NAME_LIMIT))
    else $error("name count beyond buffer depth");

  // A name byte is stored only inside an open entity with room left.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (ent_r && (cnt_r != CW'(NAME_LIMIT))))
    else $error("name byte stored outside an entity or into a full buffer");

  // A waiting output item stays valid and unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_run_end) &&
       $stable(out_text_end)))
    else $error("output item changed while waiting");
`endif

endmodule

// ===== sv/xed_ctrl.sv =====
// ----------------------------------------------------------------------------
// xed_ctrl
// Controller of the XML entity decoder. It plans the output segments of each
// accepted item and steps through them one byte per free output slot.
// ----------------------------------------------------------------------------
module xed_ctrl #(
  parameter int NAME_LIMIT = xed_pkg::NAME_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_last,
  input  xed_pkg::xed_stat_t              st,
  output xed_pkg::xed_cmd_t               cmd,
  output logic [$clog2(NAME_LIMIT+1)-1:0] idx
);
  import xed_pkg::*;

  localparam int CW = $clog2(NAME_LIMIT + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEG_N-1:0] seg_r, seg_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             keep_r, keep_nxt;

  logic [SEG_N-1:0] cur, rest;
  logic             seg_end;
  src_sel_t         cur_sel;

  // Current segment is the lowest pending one.
  assign cur  = seg_r & (~seg_r + SEG_N'(1));
  assign rest = seg_r & ~cur;

  always_comb begin
    if (cur[SEG_REL1] || cur[SEG_REL2]) begin
      seg_end = st.rel_end;
      cur_sel = SRC_REL;
    end else if (cur[SEG_DEC]) begin
      seg_end = st.dec_end;
      cur_sel = SRC_DEC;
    end else if (cur[SEG_SEMI]) begin
      seg_end = 1'b1;
      cur_sel = SRC_SEMI;
    end else begin
      seg_end = 1'b1;
      cur_sel = SRC_LIT;
    end
  end

  // Planning of a new item and sequencing of its result bytes.
  always_comb begin
    cmd       = '0;
    cmd.sel   = SRC_IN;
    state_nxt = state_r;
    seg_nxt   = seg_r;
    idx_nxt   = idx_r;
    keep_nxt  = keep_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          cmd.accept = 1'b1;
          seg_nxt    = '0;
          keep_nxt   = 1'b0;
          if (!st.ent) begin
            if (st.in_amp) begin
              cmd.open          = 1'b1;
              seg_nxt[SEG_REL2] = in_last;
            end else begin
              // Plain text goes straight to the output register.
              cmd.load    = 1'b1;
              cmd.run_end = 1'b1;
              cmd.sel     = SRC_IN;
            end
          end else if (st.in_semi) begin
            if (st.known) begin
              seg_nxt[SEG_DEC] = 1'b1;
            end else begin
              seg_nxt[SEG_REL1] = 1'b1;
              seg_nxt[SEG_SEMI] = 1'b1;
            end
          end else if (st.in_amp) begin
            seg_nxt[SEG_REL1] = 1'b1;
            seg_nxt[SEG_REL2] = in_last;
            keep_nxt          = 1'b1;
          end else if (st.full) begin
            seg_nxt[SEG_REL1] = 1'b1;
            seg_nxt[SEG_LIT]  = 1'b1;
          end else begin
            cmd.append        = 1'b1;
            seg_nxt[SEG_REL2] = in_last;
          end
          if (seg_nxt != '0) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (st.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = cur_sel;
          cmd.run_end = seg_end && (rest == '0);
          if (seg_end) begin
            seg_nxt = rest;
            idx_nxt = '0;
            // Closing a release or a decode empties the name.
            if (cur[SEG_REL1]) begin
              cmd.clr_name = 1'b1;
              cmd.clr_ent  = !keep_r;
            end
            if (cur[SEG_DEC] || cur[SEG_REL2]) begin
              cmd.clr_name = 1'b1;
              cmd.clr_ent  = 1'b1;
            end
            if (rest == '0) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        seg_nxt   = '0;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seg_r   <= '0;
      idx_r   <= '0;
      keep_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      idx_r   <= idx_nxt;
      keep_r  <= keep_nxt;
    end
  end

  assign idx = idx_r;

`ifndef SYNTHESIS
  // While emitting there is always a segment pending.
  a_run_has_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (seg_r != '0))
    else $error("emitting with no segment pending");

  // A byte is loaded only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> st.out_free)
    else $error("output register overwritten");

  // The byte index restarts at zero for every item.
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (idx_r == '0))
    else $error("byte index not cleared between items");
`endif

endmodule

// ===== sv/xml_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Streaming XML entity decoder: text bytes in, decoded UTF-8 bytes out.
// ----------------------------------------------------------------------------
// Ordinary text bytes and bytes of an entity name are accepted one per cycle
// while the output register is free; a plain byte is written straight into
// the output register. An item that decodes an entity or releases a pending
// name has its result bytes (one to thirteen) loaded one at a time into the
// single output register, stalling under back-pressure; no new item is taken
// until the last is loaded. Known names and numeric references are
// converted to one to four UTF-8 bytes; unknown or broken entities come out
// as the original literal bytes. out_run_end marks the last byte caused by an
// input item and out_text_end the last byte of an item flagged with in_last.
module xml_entity_decoder #(
  parameter int NAME_LIMIT = xed_pkg::NAME_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_text_end
);
  import xed_pkg::*;

  localparam int CW = $clog2(NAME_LIMIT + 1);

  xed_cmd_t      cmd;
  xed_stat_t     st;
  logic [CW-1:0] idx;

  // Sequencing of segments and result bytes.
  xed_ctrl #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_last  (in_last),
    .st       (st),
    .cmd      (cmd),
    .idx      (idx)
  );

  // Name storage, decoding and output register.
  xed_datapath #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .idx          (idx),
    .st           (st),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end),
    .out_text_end (out_text_end)
  );

endmodule

// ===== dv/xed_checker.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder checker
// Watches both channels of the decoder, keeps its own model of the entity
// state, works out the decoded bytes that each accepted text item causes and
// compares every accepted output byte with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module xed_checker #(
  parameter int NAME_LIMIT = xed_pkg::NAME_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_run_end,
  input  logic       out_text_end,
  output int         fail_count,
  output int         bytes_due,
  output int         items_seen,
  output int         bytes_seen,
  output int         named_hits,
  output int         numeric_hits,
  output int         literal_runs
);
  timeunit 1ns;
  timeprecision 1ps;
  import xed_pkg::*;

  localparam int REPORT_CAP = 60;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       text_end;
  } out_beat_t;

  // Decoded bytes still owed by the block, oldest first.
  out_beat_t  due_q[$];
  // Bytes caused by the item being decoded.
  logic [7:0] step_q[$];

  // Model of the pending entity.
  logic       entity_open;
  logic [7:0] name_buf [NAME_LIMIT];
  int         name_len;

  string      known_names [6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};
  logic [7:0] known_bytes [6] = '{CH_AMP, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20};

  function automatic logic name_is(input string word);
    if (word.len() != name_len) return 1'b0;
    for (int i = 0; i < name_len; i++) begin
      if (name_buf[i] != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_of(input logic [7:0] c, input logic hex);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (hex && c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (hex && c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // The '&' and every held name byte come out as plain text.
  task automatic flush_name();
    step_q.push_back(CH_AMP);
    for (int i = 0; i < name_len; i++) step_q.push_back(name_buf[i]);
    literal_runs++;
  endtask

  task automatic push_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      step_q.push_back(cp[7:0]);
    end else if (cp < 32'h800) begin
      step_q.push_back({3'b110, cp[10:6]});
      step_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 32'h1_0000) begin
      step_q.push_back({4'b1110, cp[15:12]});
      step_q.push_back({2'b10, cp[11:6]});
      step_q.push_back({2'b10, cp[5:0]});
    end else begin
      step_q.push_back({5'b11110, cp[20:18]});
      step_q.push_back({2'b10, cp[17:12]});
      step_q.push_back({2'b10, cp[11:6]});
      step_q.push_back({2'b10, cp[5:0]});
    end
  endtask

  // A ';' has closed the name: known word, numeric reference or verbatim copy.
  task automatic close_entity();
    logic [31:0] code;
    logic        hex;
    logic        found;
    int          pos;
    int          d;
    found = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (!found && name_is(known_names[i])) begin
        step_q.push_back(known_bytes[i]);
        found = 1'b1;
      end
    end
    if (found) begin
      named_hits++;
    end else if (name_len > 1 && name_buf[0] == CH_HASH) begin
      hex  = (name_buf[1] == CH_LX) || (name_buf[1] == CH_UX);
      pos  = hex ? 2 : 1;
      code = '0;
      while (pos < name_len) begin
        d = digit_of(name_buf[pos], hex);
        if (d < 0) break;
        code = code * (hex ? 32'd16 : 32'd10) + 32'(d);
        pos++;
      end
      if (code == 0 || code > CP_MAX) code = {24'b0, CH_QMARK};
      push_utf8(code);
      numeric_hits++;
    end else begin
      flush_name();
      step_q.push_back(CH_SEMI);
    end
  endtask

  // Advance the entity model by one text item and queue what it causes.
  task automatic predict_item(input logic [7:0] b, input logic last);
    logic      handled;
    out_beat_t beat;
    handled = 1'b0;
    step_q.delete();
    if (entity_open) begin
      if (b == CH_SEMI) begin
        close_entity();
        entity_open = 1'b0;
        name_len    = 0;
        handled     = 1'b1;
      end else if (b == CH_AMP) begin
        flush_name();
        name_len = 0;
        handled  = 1'b1;
      end else if (name_len >= NAME_LIMIT) begin
        // Name too long: release it, then treat the byte as ordinary text.
        flush_name();
        entity_open = 1'b0;
        name_len    = 0;
      end else begin
        name_buf[name_len] = b;
        name_len++;
        handled = 1'b1;
      end
    end
    if (!handled) begin
      if (b == CH_AMP) begin
        entity_open = 1'b1;
        name_len    = 0;
      end else begin
        step_q.push_back(b);
      end
    end
    // End of text leaves no entity open.
    if (last && entity_open) begin
      flush_name();
      entity_open = 1'b0;
      name_len    = 0;
    end
    foreach (step_q[i]) begin
      beat.data     = step_q[i];
      beat.run_end  = (i == step_q.size() - 1);
      beat.text_end = last && (i == step_q.size() - 1);
      due_q.push_back(beat);
    end
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $error("%s mismatch: expected %02h, got %02h", field, want, got);
    end
  endtask

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    out_beat_t beat;
    if (!rst_n) begin
      entity_open = 1'b0;
      name_len    = 0;
      foreach (name_buf[i]) name_buf[i] = '0;
      due_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_byte, in_last);
        items_seen++;
      end
      if (out_valid && out_ready) begin
        bytes_seen++;
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("out_byte %02h arrived with no decoded byte outstanding", out_byte);
        end else begin
          beat = due_q.pop_front();
          check_field("out_byte", beat.data, out_byte);
          check_field("out_run_end", {7'b0, beat.run_end}, {7'b0, out_run_end});
          check_field("out_text_end", {7'b0, beat.text_end}, {7'b0, out_text_end});
        end
      end
    end
    bytes_due = due_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// XML entity decoder testbench
// Feeds escaped text into the decoder, first a short directed string with the
// corner cases, then random entities, numeric references and noise across
// four traffic phases with varying gaps and back-pressure, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import xed_pkg::*;

  localparam int PHASE_ITEMS  = 120;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 32;
  localparam int LIMIT_CYCLES = 500000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_text_end;

  int fail_count;
  int bytes_due;
  int items_seen;
  int bytes_seen;
  int named_hits;
  int numeric_hits;
  int literal_runs;

  int          gap_pct;
  int          stall_pct;
  logic        hold_req;
  int          hold_left;
  int unsigned cycle_count;
  logic [7:0]  piece[$];

  string known_names [6] = '{"amp", "lt", "gt", "quot", "apos", "nbsp"};

  xml_entity_decoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end),
    .out_text_end (out_text_end)
  );

  xed_checker decode_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end),
    .out_text_end (out_text_end),
    .fail_count   (fail_count),
    .bytes_due    (bytes_due),
    .items_seen   (items_seen),
    .bytes_seen   (bytes_seen),
    .named_hits   (named_hits),
    .numeric_hits (numeric_hits),
    .literal_runs (literal_runs)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a run that takes this long has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one text item, with random idle cycles first, and wait for it to go.
  task automatic send_item(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender stays quiet until every decoded byte has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) piece.push_back(s[i]);
  endtask

  function automatic logic [7:0] name_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_AMP || c == CH_SEMI);
    return c;
  endfunction

  // Code points spread over every UTF-8 length, the bounds and the bad values.
  function automatic logic [31:0] pick_code();
    logic [31:0] edges [9] = '{32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                               32'h1_0000, 32'h10_FFFF, 32'h11_0000, 32'hD800};
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return $urandom_range(32'h7F, 32'h1);
      2: return $urandom_range(32'h7FF, 32'h80);
      3: return $urandom_range(32'hFFFF, 32'h800);
      4: return $urandom_range(32'h10_FFFF, 32'h1_0000);
      5: return $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
      default: return edges[$urandom_range(0, 8)];
    endcase
  endfunction

  // One numeric reference after "&#": hex or decimal, sometimes wrapping 2^32.
  task automatic build_numeric(input logic hex);
    logic [31:0] code;
    string       digits;
    logic [7:0]  c;
    code = pick_code();
    if (hex) begin
      piece.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      digits = $sformatf("%0h", code);
      if ($urandom_range(0, 9) == 0)
        digits = {$sformatf("%0h", $urandom_range(15, 1)), $sformatf("%08h", code)};
      else if (digits.len() < 9 && $urandom_range(0, 3) == 0)
        digits = {"0", digits};
    end else begin
      digits = $sformatf("%0d", code);
      if ($urandom_range(0, 9) == 0)
        digits = {$sformatf("%0d", $urandom_range(9, 5)),
                  $sformatf("%09d", $urandom_range(999999999, 0))};
      else if (digits.len() < 10 && $urandom_range(0, 3) == 0)
        digits = {"0", digits};
    end
    if (code == 0 && $urandom_range(0, 1)) digits = "";
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1)) c = c - 8'h20;
      piece.push_back(c);
    end
    // A stray non-digit ends the number early.
    if ($urandom_range(0, 9) == 0) piece.push_back("g");
  endtask

  // Build the next stretch of text: mostly well-formed, some broken, some noise.
  task automatic build_piece();
    int kind;
    int len;
    logic [7:0] c;
    piece.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_AMP);
        piece.push_back(c);
      end
    end else if (kind < 50) begin
      piece.push_back(CH_AMP);
      push_text(known_names[$urandom_range(0, 5)]);
      piece.push_back(CH_SEMI);
    end else if (kind < 78) begin
      piece.push_back(CH_AMP);
      piece.push_back(CH_HASH);
      build_numeric(kind < 64);
      piece.push_back(CH_SEMI);
    end else if (kind < 86) begin
      // Unknown name, possibly empty, closed properly.
      piece.push_back(CH_AMP);
      len = $urandom_range(0, 11);
      repeat (len) piece.push_back(name_byte());
      piece.push_back(CH_SEMI);
    end else if (kind < 93) begin
      // Name never closed: cut off by the next '&', by length or by end of text.
      piece.push_back(CH_AMP);
      len = $urandom_range(0, 13);
      repeat (len) piece.push_back(name_byte());
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) piece.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus.
  initial begin
    int gap_table   [4] = '{0, 45, 0, 27};
    int stall_table [4] = '{0, 0, 45, 27};
    int sent;
    logic last_flag;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = '0;
    in_last   = 1'b0;
    hold_req  = 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed text: over-long name with both byte extremes, zero code
    // point, empty name, lone hash, second ampersand and an entity cut by end
    // of text.
    piece.delete();
    piece.push_back(CH_AMP);
    piece.push_back(8'h00);
    push_text("bcdefghijk");
    piece.push_back(8'hFF);
    push_text("&#0;&;&#;&a&b");
    foreach (piece[i]) send_item(piece[i], i == piece.size() - 1);
    drain();

    for (int p = 0; p < 4; p++) begin
      gap_pct   = gap_table[p];
      stall_pct = stall_table[p];
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        build_piece();
        foreach (piece[i]) begin
          if (i == piece.size() - 1) last_flag = ($urandom_range(0, 11) == 0);
          else last_flag = ($urandom_range(0, 49) == 0);
          send_item(piece[i], last_flag);
          sent++;
          // Long output hold-off while text keeps coming, to fill the block.
          if (p == 0 && sent == 40) hold_req = 1'b1;
        end
      end
      drain();
    end

    $display("Covered %0d text items and %0d decoded bytes in four traffic phases.",
             items_seen, bytes_seen);
    $display("Named entities %0d, numeric references %0d, literal releases %0d, %0d cycles.",
             named_hits, numeric_hits, literal_runs, cycle_count);
    if (fail_count == 0 && bytes_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
